// ===== sv/nearest_palette_search_macros.svh =====
// Assertion macros for the palette search RTL.
`ifndef NEAREST_PALETTE_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nps_pkg.sv =====
// Types and constants of the nearest palette search block.
package nps_pkg;

    localparam int CH_W   = 8;   // stored channel width
    localparam int PT_W   = 10;  // query channel width, two's complement
    localparam int SIZE_W = 9;   // palette size register width
    localparam int OUT_W  = 8;   // result index width
    localparam int ABS_W  = 9;   // magnitude of a channel difference
    localparam int SQ_W   = 2 * ABS_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int NCH    = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Channel 0 is red, then green, blue, alpha.
    typedef logic [NCH-1:0][PT_W-1:0] t_point;
    typedef logic [NCH-1:0][CH_W-1:0] t_entry;

    // Magnitude of a query channel minus a stored channel.
    function automatic logic [ABS_W-1:0] abs_diff(input logic [PT_W-1:0] p,
                                                  input logic [CH_W-1:0] e);
        logic [PT_W:0] d;
        logic [PT_W:0] m;
        d = {p[PT_W-1], p} - (PT_W + 1)'(e);
        m = d[PT_W] ? (~d + 1'b1) : d;
        return m[ABS_W-1:0];
    endfunction

endpackage

// ===== sv/nps_if.sv =====
// Valid/ready channels of the palette search: input words and result words.
interface nps_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [7:0]                   entry_index;
    logic signed [nps_pkg::PT_W-1:0] red;
    logic signed [nps_pkg::PT_W-1:0] green;
    logic signed [nps_pkg::PT_W-1:0] blue;
    logic signed [nps_pkg::PT_W-1:0] alpha;

    modport source (output valid, op, entry_index, red, green, blue, alpha,
                    input ready);
    modport sink   (input valid, op, entry_index, red, green, blue, alpha,
                    output ready);
endinterface

interface nps_out_if;
    logic                       valid;
    logic                       ready;
    logic [nps_pkg::OUT_W-1:0]  best_index;

    modport source (output valid, best_index, input ready);
    modport sink   (input valid, best_index, output ready);
endinterface

// ===== sv/nearest_palette_search.sv =====
// Top level of the nearest palette search: control, RAM and distance pipeline.
//
//  channel   dir   width               what one word carries
//  i_in      in    1+8+4x10 signed     load of one palette entry, or a query point
//  o_out     out   8                   index of the nearest entry, one per query
//  i_cfg_*   in    9                   palette size, written while idle
//
//  A load word goes straight into the RAM. A query scans min(size, PALETTE_DEPTH)
//  entries: the palette RAM has one read port, so the scan reads one entry a cycle.
//  While a query runs, i_in.ready is low; a result waiting in the output register
//  does not block loads or the start of the next query.
//  Reset is synchronous and active low; it clears control state only. The palette
//  RAM holds garbage until software loads it, and needs no clearing pass.
module nearest_palette_search #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [nps_pkg::SIZE_W-1:0] i_cfg_wdata,
    nps_in_if.sink                     i_in,
    nps_out_if.source                  o_out
);

    import nps_pkg::*;

    `include "nearest_palette_search_macros.svh"

    // Address width of the RAM, and a counter width that can also hold the depth.
    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int KW = (CW > SIZE_W) ? CW : SIZE_W;

    t_state            r_state;
    t_state            n_state;
    logic [SIZE_W-1:0] r_size;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_addr;
    logic [CW-1:0]     n_addr;
    t_point            r_point;
    logic [AW-1:0]     r_best;
    logic [DIST_W-1:0] r_best_d;
    logic              r_rd_valid;
    logic [AW-1:0]     r_rd_idx;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_best;

    logic              accept;
    logic              start_query;
    logic              start_search;
    logic              out_load;
    logic [KW-1:0]     size_k;
    logic [KW-1:0]     clamp_k;
    logic              ram_we;
    logic              ram_re;
    t_entry            ram_wdata;
    t_entry            ram_rdata;
    logic              dist_valid;
    logic [AW-1:0]     dist_idx;
    logic [DIST_W-1:0] dist_val;
    logic              dist_busy;

    // The palette size is clamped to the depth of the store.
    assign size_k  = KW'(r_size);
    assign clamp_k = (size_k > KW'(PALETTE_DEPTH)) ? KW'(PALETTE_DEPTH) : size_k;

    // Input words are taken only while the sequencer is idle.
    assign i_in.ready  = (r_state == ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign start_query = accept && (i_in.op == OP_QUERY);

    // Loads only happen in idle and reads only during a scan, so the RAM never
    // sees a read and a write to the same entry in flight together. A slot beyond
    // the store is dropped.
    assign ram_we = accept && (i_in.op == OP_LOAD)
                  && (KW'(i_in.entry_index) < KW'(PALETTE_DEPTH));
    assign ram_wdata = {i_in.alpha[CH_W-1:0], i_in.blue[CH_W-1:0],
                        i_in.green[CH_W-1:0], i_in.red[CH_W-1:0]};

    nps_ram #(
        .WIDTH (NCH * CH_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    nps_dist #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (r_point),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_entry (ram_rdata),
        .o_valid (dist_valid),
        .o_idx   (dist_idx),
        .o_dist  (dist_val),
        .o_busy  (dist_busy)
    );

    // Sequencer: issue one RAM read per cycle, wait for the pipeline to empty,
    // then hand the winner to the output register once it is free.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_count      = r_count;
        ram_re       = 1'b0;
        out_load     = 1'b0;
        start_search = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start_query) begin
                    start_search = 1'b1;
                    n_addr       = '0;
                    n_count      = CW'(clamp_k);
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr < r_count) begin
                    ram_re = 1'b1;
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_valid && !dist_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= ram_re;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. A strict less-than keeps the lower index on a tie,
    // since entries arrive in ascending order.
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_count  <= n_count;
        r_rd_idx <= r_addr[AW-1:0];
        if (start_search) begin
            r_point  <= {i_in.alpha, i_in.blue, i_in.green, i_in.red};
            r_best   <= '0;
            r_best_d <= DIST_MAX;
        end else if (dist_valid && (dist_val < r_best_d)) begin
            r_best   <= dist_idx;
            r_best_d <= dist_val;
        end
        if (out_load) begin
            r_out_best <= OUT_W'(r_best);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.best_index = r_out_best;

    `NPS_ASSERT_NOW(a_write_only_idle, ram_we, r_state == ST_IDLE, "palette write during a search")
    `NPS_ASSERT_NOW(a_dist_in_search, dist_valid, r_state == ST_SCAN || r_state == ST_DRAIN, "distance outside a search")
    `NPS_ASSERT_NOW(a_dist_idx_range, dist_valid, CW'(dist_idx) < r_count, "distance for an entry beyond the size")
    `NPS_ASSERT_NOW(a_finish_has_best, r_state == ST_FINISH && r_count != '0, r_best_d != DIST_MAX, "nonempty search finished with no candidate")
    `NPS_ASSERT_NEXT(a_query_starts, start_query, r_state == ST_SCAN, "query accepted but scan not started")

endmodule

// ===== sv/nps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/nps_dist.sv =====
// Three-stage squared Euclidean distance pipeline over four channels.
module nps_dist #(
    parameter int AW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nps_pkg::t_point             i_point,
    input  logic                        i_valid,
    input  logic [AW-1:0]               i_idx,
    input  nps_pkg::t_entry             i_entry,
    output logic                        o_valid,
    output logic [AW-1:0]               o_idx,
    output logic [nps_pkg::DIST_W-1:0]  o_dist,
    output logic                        o_busy
);

    import nps_pkg::*;

    logic [NCH-1:0][ABS_W-1:0] r_abs;
    logic [NCH-1:0][SQ_W-1:0]  r_sq;
    logic [DIST_W-1:0]         r_sum;
    logic [2:0]                r_vld;
    logic [AW-1:0]             r_idx1;
    logic [AW-1:0]             r_idx2;
    logic [AW-1:0]             r_idx3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NCH; k++) begin
            r_abs[k] <= abs_diff(i_point[k], i_entry[k]);
            r_sq[k]  <= SQ_W'(r_abs[k]) * SQ_W'(r_abs[k]);
        end
        r_sum  <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1])
                + DIST_W'(r_sq[2]) + DIST_W'(r_sq[3]);
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
    end

    assign o_valid = r_vld[2];
    assign o_idx   = r_idx3;
    assign o_dist  = r_sum;
    assign o_busy  = |r_vld;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for nearest_palette_search: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
    import nps_pkg::*;

    localparam int DEPTH       = 256;
    localparam int SETTLE_CYC  = 16;    // lets a trailing load word finish before a config write
    localparam int TAIL_CYC    = 300;   // one full scan of the largest palette, and some margin
    localparam int HOLD_CYC    = 800;   // long result back-pressure, several full queries' worth
    localparam int N_DIRECTED  = 20;
    localparam int N_PHASES    = 9;
    localparam int PRESSURE_PH = 3;
    localparam int PAUSE_PH    = 4;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_e;

    // One row of the directed table. For a config row, arg is the palette size;
    // otherwise it is the entry index of the word. When fixed is set, want is the
    // index that the block must return, typed in by hand.
    typedef struct packed {
        row_kind_e kind;
        int        arg;
        int        r, g, b, a;
        bit        fixed;
        int        want;
    } dir_row_t;

    // One input word as the predictor sees it. Channel 0 of pt is red.
    typedef struct packed {
        logic         op;
        logic [7:0]   slot;
        t_point       pt;
    } palette_word_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    nps_in_if  in_ch ();
    nps_out_if out_ch ();

    nearest_palette_search #(
        .PALETTE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // The predictor's own copy of the palette and of the size register. The
    // written flags keep queries away from entries that were never loaded, and
    // fill_mark counts the leading run of loaded entries.
    t_entry            palette_mem [DEPTH];
    bit                written [DEPTH];
    int                fill_mark = 0;
    logic [SIZE_W-1:0] size_reg = '0;

    // Expected result indexes, oldest first.
    logic [OUT_W-1:0]  pending_index [$];
    logic [OUT_W-1:0]  want_index;
    int                mismatches = 0;

    // Idle rates in percent, and a request for a long back-pressure stretch that
    // the result sink picks up and counts down on its own.
    int                src_idle_pct  = 37;
    int                sink_idle_pct = 67;
    int                stall_request = 0;

    int phase_size  [N_PHASES] = '{5, 16, 0, 2, 64, 256, 511, 1, 9};
    int phase_items [N_PHASES] = '{150, 150, 60, 120, 150, 280, 40, 60, 100};

    // Entries 0 and 3 are equal so that the lower index must win the tie. Entry 2
    // is loaded with values outside a byte, so only the low byte of each channel,
    // 255, 0, 255, 0, may be kept. Entry 255 exercises the top slot.
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_QUERY,   0,  511, -256,    0,    0, 1'b1, 0},  // empty palette after reset
        '{ROW_LOAD,    0,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_LOAD,    1,  255,  255,  255,  255, 1'b0, 0},
        '{ROW_LOAD,    2,   -1,  256,  511, -256, 1'b0, 0},
        '{ROW_LOAD,    3,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_LOAD,  255,  128,   64,   32,   16, 1'b0, 0},
        '{ROW_CFG,     4,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_QUERY,   0,    0,    0,    0,    0, 1'b1, 0},  // tie between entries 0 and 3
        '{ROW_QUERY,   0,  255,  255,  255,  255, 1'b1, 1},
        '{ROW_QUERY,   0,  511,  511,  511,  511, 1'b1, 1},
        '{ROW_QUERY,   0, -256, -256, -256, -256, 1'b1, 0},
        '{ROW_QUERY,   0,  255,    0,  255,    0, 1'b1, 2},
        '{ROW_QUERY, 255,  300,  -10,  400,  -50, 1'b0, 0},  // entry index ignored on a query
        '{ROW_QUERY, 170,  100,  100,  100,  100, 1'b0, 0},
        '{ROW_CFG,     1,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_QUERY,   0,  255,  255,  255,  255, 1'b1, 0},  // only entry 0 is searched
        '{ROW_CFG,     0,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_QUERY,  85,    0,    0,    0,    0, 1'b1, 0},  // size written back to zero
        '{ROW_CFG,     3,    0,    0,    0,    0, 1'b0, 0},
        '{ROW_QUERY,   0,  130,  130,  130,  130, 1'b0, 0}
    };

    // Predictor: squared Euclidean distance over the four channels against every
    // searched entry, strict less-than so that the lowest index keeps a tie. The
    // search is clipped to the store depth when the size register is larger.
    function automatic logic [OUT_W-1:0] nearest_entry(input t_point pt);
        int     span;
        int     best;
        int     diff;
        longint d;
        longint best_d;
        span   = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
        best   = 0;
        best_d = 64'h7fff_ffff;
        for (int i = 0; i < span; i++) begin
            d = 0;
            for (int c = 0; c < NCH; c++) begin
                diff = int'($signed(pt[c])) - int'(palette_mem[i][c]);
                d += longint'(diff) * longint'(diff);
            end
            if (d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        return best[OUT_W-1:0];
    endfunction

    // A query channel value anywhere in the legal range -256..511.
    function automatic int rand_point_ch();
        return int'($urandom_range(767)) - 256;
    endfunction

    // Random words for a phase whose search covers span entries. Until every
    // searched entry is loaded, the palette is filled in order; after that most
    // words are queries, mostly near a stored color, with stray loads mixed in. Loads
    // now and then copy a stored color to make ties, or carry out-of-byte data.
    function automatic palette_word_t make_random_word(input int span);
        palette_word_t w;
        int            pick;
        int            src;
        int            v;
        w.slot = 8'($urandom_range(255));
        pick   = $urandom_range(99);
        if (fill_mark < span || $urandom_range(99) >= 70) begin
            w.op = OP_LOAD;
            if (fill_mark < span)
                w.slot = fill_mark[7:0];
            src = (fill_mark > 0) ? $urandom_range(fill_mark - 1) : 0;
            for (int c = 0; c < NCH; c++) begin
                if (pick < 10)
                    v = rand_point_ch();
                else if (pick < 25 && fill_mark > 0)
                    v = int'(palette_mem[src][c]);
                else if (pick < 35)
                    v = ($urandom_range(1) != 0) ? 255 : 0;
                else
                    v = $urandom_range(255);
                w.pt[c] = v[PT_W-1:0];
            end
        end else begin
            w.op = OP_QUERY;
            src  = (span > 0) ? $urandom_range(span - 1) : 0;
            for (int c = 0; c < NCH; c++) begin
                if (span == 0 || pick < 30)
                    v = rand_point_ch();
                else if (pick < 65)
                    v = int'(palette_mem[src][c]);
                else
                    v = int'(palette_mem[src][c]) + int'($urandom_range(16)) - 8;
                w.pt[c] = v[PT_W-1:0];
            end
        end
        return w;
    endfunction

    // Offers one word, with random idle cycles in front of it, and waits until
    // it is taken. Valid stays high after the accepting edge so that a word that
    // follows straight on never sees valid lowered and raised in one time step.
    // On acceptance the predictor absorbs the word.
    task automatic send_word(input palette_word_t w, input bit fixed, input int want);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= w.op;
        in_ch.entry_index <= w.slot;
        in_ch.red         <= w.pt[0];
        in_ch.green       <= w.pt[1];
        in_ch.blue        <= w.pt[2];
        in_ch.alpha       <= w.pt[3];
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (w.op == OP_LOAD) begin
            for (int c = 0; c < NCH; c++)
                palette_mem[w.slot][c] = w.pt[c][CH_W-1:0];
            written[w.slot] = 1'b1;
            while (fill_mark < DEPTH && written[fill_mark])
                fill_mark++;
        end else if (fixed) begin
            pending_index.push_back(want[OUT_W-1:0]);
        end else begin
            pending_index.push_back(nearest_entry(w.pt));
        end
    endtask

    // Stops offering words and waits until every query has answered; a load can
    // give no answer, so a few more cycles let the last one settle.
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (pending_index.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // The size register is only written while the block is idle.
    task automatic write_palette_size(input int value);
        wait_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[SIZE_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_reg     = value[SIZE_W-1:0];
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result sink. Ready is drawn every cycle from the current idle rate, except
    // during a requested hold, which this process counts down by itself while
    // the sender keeps offering words and the block backs up.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Every result word taken is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_index.size() == 0) begin
                $display("%0t ns: unexpected result word: expected none, actual %0d",
                         $time, out_ch.best_index);
                mismatches++;
            end else begin
                want_index = pending_index.pop_front();
                if (out_ch.best_index !== want_index) begin
                    $display("%0t ns: best_index mismatch: expected %0d, actual %0d",
                             $time, want_index, out_ch.best_index);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        palette_word_t w;
        dir_row_t      row;
        int            span;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.red         <= '0;
        in_ch.green       <= '0;
        in_ch.blue        <= '0;
        in_ch.alpha       <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the first idle regime: sender idle 37 percent,
        // receiver idle 67 percent.
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                write_palette_size(row.arg);
            end else begin
                w.op    = (row.kind == ROW_QUERY) ? OP_QUERY : OP_LOAD;
                w.slot  = row.arg[7:0];
                w.pt[0] = row.r[PT_W-1:0];
                w.pt[1] = row.g[PT_W-1:0];
                w.pt[2] = row.b[PT_W-1:0];
                w.pt[3] = row.a[PT_W-1:0];
                send_word(w, row.fixed, row.want);
            end
        end

        // Random phases, each with its own palette size. The first three keep
        // the sender idle 37 and the receiver 67 percent, the next three swap
        // the two, and the last three run without idling. Most phases use small
        // palettes; the full store and an oversize setting get few queries.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            src_idle_pct  = (ph < 3) ? 37 : (ph < 6) ? 67 : 0;
            sink_idle_pct = (ph < 3) ? 67 : (ph < 6) ? 37 : 0;
            write_palette_size(phase_size[ph]);
            span = (phase_size[ph] > DEPTH) ? DEPTH : phase_size[ph];
            for (int n = 0; n < phase_items[ph]; n++) begin
                // Hold the results back for a long stretch so the block fills up.
                if (ph == PRESSURE_PH && n == 20)
                    stall_request = HOLD_CYC;
                // Pause the sender once until every answer is in.
                if (ph == PAUSE_PH && n == phase_items[ph] / 2)
                    wait_results();
                w = make_random_word(span);
                send_word(w, 1'b0, 0);
            end
        end

        wait_results();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_index.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Safety net well beyond the slowest correct run.
    initial begin : watchdog
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nps_pkg.sv
sv/nps_if.sv
sv/nps_ram.sv
sv/nps_dist.sv
sv/nearest_palette_search.sv
verif/tb.sv
